### src/fsn_pkg.sv
// Shared types, constants and float helper functions for the square root unit.
package fsn_pkg;

   localparam logic [31:0] PosInfBits = 32'h7F80_0000;
   localparam logic [31:0] OneBits    = 32'h3F80_0000;
   localparam logic [31:0] BiasTerm   = 32'h2000_0000;
   localparam logic [31:0] MantTerm   = 32'h0040_0000;
   localparam logic [31:0] QuietBit   = 32'h0040_0000;
   localparam logic [31:0] ExpOne     = 32'h0080_0000;
   localparam int          DivBits    = 26;

   typedef struct packed {
      logic load;
      logic init;
      logic xshift;
      logic set_inf;
      logic gload;
      logic gshift;
      logic div_setup;
      logic div_iter;
      logic div_round;
      logic add;
      logic update;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic x_norm;
      logic g_norm;
      logic g_zero;
      logic g_inf;
      logic n_equal;
   } sts_type;

   // be: biased exponent, m: quotient with leading one at bit 25, st: sticky
   function automatic logic [31:0] fsn_round(input logic signed [10:0] be,
                                             input logic [25:0] m,
                                             input logic st);
      logic [25:0] sh_m;
      logic [25:0] mask;
      logic        lost;
      logic        inc;
      logic [10:0] amt;
      logic [31:0] res;
      sh_m = '0;
      mask = '0;
      lost = 1'b0;
      inc  = 1'b0;
      amt  = '0;
      res  = '0;
      if (be >= 11'sd255) begin
         res = PosInfBits;
      end else if (be >= 11'sd1) begin
         inc = m[1] & (m[0] | st | m[2]);
         res = {1'b0, be[7:0], m[24:2]} + 32'(inc);
      end else begin
         amt = 11'(11'sd1 - be);
         if (amt >= 11'd26) begin
            res = '0;
         end else begin
            sh_m = m >> amt[4:0];
            mask = (26'd1 << amt[4:0]) - 26'd1;
            lost = |(m & mask);
            inc  = sh_m[1] & (sh_m[0] | lost | st | sh_m[2]);
            res  = {9'd0, sh_m[24:2]} + 32'(inc);
         end
      end
      return res;
   endfunction

   // sum of two non-negative floats, round to nearest even
   function automatic logic [31:0] fsn_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [7:0]  ebe;
      logic [7:0]  d;
      logic [26:0] bs;
      logic [26:0] bsh;
      logic [26:0] mask;
      logic [27:0] sum;
      logic [26:0] m;
      logic [8:0]  e;
      logic        inc;
      logic [31:0] res;
      hi = a;
      lo = b;
      ma = '0;
      mb = '0;
      ebe = '0;
      d = '0;
      bs = '0;
      bsh = '0;
      mask = '0;
      sum = '0;
      m = '0;
      e = '0;
      inc = 1'b0;
      res = '0;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
         res = PosInfBits;
      end else if (a[30:23] == 8'h00 && b[30:23] == 8'h00) begin
         res = a + b;
      end else begin
         if (a[30:0] < b[30:0]) begin
            hi = b;
            lo = a;
         end
         ma  = {1'b1, hi[22:0]};
         mb  = {lo[30:23] != 8'h00, lo[22:0]};
         ebe = (lo[30:23] == 8'h00) ? 8'd1 : lo[30:23];
         d   = hi[30:23] - ebe;
         bs  = {mb, 3'b000};
         if (d >= 8'd27) begin
            bsh = {26'd0, |mb};
         end else begin
            bsh    = bs >> d[4:0];
            mask   = (27'd1 << d[4:0]) - 27'd1;
            bsh[0] = bsh[0] | (|(bs & mask));
         end
         sum = {1'b0, ma, 3'b000} + {1'b0, bsh};
         e   = {1'b0, hi[30:23]};
         if (sum[27]) begin
            m = {sum[27:2], sum[1] | sum[0]};
            e = e + 9'd1;
         end else begin
            m = sum[26:0];
         end
         inc = m[2] & (m[1] | m[0] | m[3]);
         if (e >= 9'd255) begin
            res = PosInfBits;
         end else begin
            res = {1'b0, e[7:0], m[25:3]} + 32'(inc);
         end
      end
      return res;
   endfunction

   // multiply a non-negative float by one half, round to nearest even
   function automatic logic [31:0] fsn_halve(input logic [31:0] b);
      logic [23:0] m;
      logic [23:0] r;
      logic [31:0] res;
      m = '0;
      r = '0;
      if (b[30:23] == 8'hFF) begin
         res = b;
      end else if (b[30:23] > 8'd1) begin
         res = b - ExpOne;
      end else begin
         m   = {b[30:23] == 8'd1, b[22:0]};
         r   = {1'b0, m[23:1]} + 24'(m[0] & m[1]);
         res = {8'd0, r};
      end
      return res;
   endfunction

endpackage

### src/fsn_if.sv
// Request and response channel interfaces of the square root unit.
interface fsn_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] operand_bits;
   modport source (output valid, output operand_bits, input ready);
   modport sink (input valid, input operand_bits, output ready);
endinterface

interface fsn_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] root_bits;
   modport source (output valid, output root_bits, input ready);
   modport sink (input valid, input root_bits, output ready);
endinterface

### src/fsn_datapath.sv
// Datapath: operand and guess registers, serial divider, adder, halver.
module fsn_datapath (
   input  logic            clock,
   input  fsn_pkg::cmd_type cmd,
   input  logic [31:0]     operand_bits,
   output fsn_pkg::sts_type sts,
   output logic [31:0]     root_bits
);
   import fsn_pkg::*;

   logic [31:0]        x_ff, x_in;
   logic [31:0]        g_ff, g_in;
   logic [23:0]        xm_ff, xm_in;
   logic signed [10:0] xe_ff, xe_in;
   logic [23:0]        gm_ff, gm_in;
   logic signed [10:0] ge_ff, ge_in;
   logic [24:0]        rem_ff, rem_in;
   logic [25:0]        quo_ff, quo_in;
   logic signed [10:0] qe_ff, qe_in;
   logic [31:0]        q_ff, q_in;
   logic [31:0]        s_ff, s_in;
   logic [31:0]        out_ff, out_in;

   logic        is_nan, is_zneg, is_inf, is_one;
   logic [31:0] spec_val;
   logic [31:0] n_val;
   logic        sub_ok;
   logic [24:0] diff;

   assign is_nan  = (x_ff[30:23] == 8'hFF) && (x_ff[22:0] != 23'd0);
   assign is_zneg = x_ff[31] || (x_ff[30:0] == 31'd0);
   assign is_inf  = (x_ff == PosInfBits);
   assign is_one  = (x_ff == OneBits);
   assign n_val   = fsn_halve(s_ff);
   assign sub_ok  = (rem_ff >= {1'b0, gm_ff});
   assign diff    = sub_ok ? (rem_ff - {1'b0, gm_ff}) : rem_ff;

   always_comb begin
      priority if (is_nan) begin
         spec_val = x_ff | QuietBit;
      end else if (is_zneg) begin
         spec_val = '0;
      end else if (is_inf) begin
         spec_val = PosInfBits;
      end else begin
         spec_val = OneBits;
      end
   end

   assign sts.special = is_nan || is_zneg || is_inf || is_one;
   assign sts.x_norm  = xm_ff[23];
   assign sts.g_norm  = gm_ff[23];
   assign sts.g_zero  = (g_ff == 32'd0);
   assign sts.g_inf   = (g_ff == PosInfBits);
   assign sts.n_equal = (n_val == g_ff);

   always_comb begin
      x_in   = x_ff;
      g_in   = g_ff;
      xm_in  = xm_ff;
      xe_in  = xe_ff;
      gm_in  = gm_ff;
      ge_in  = ge_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      qe_in  = qe_ff;
      q_in   = q_ff;
      s_in   = s_ff;
      out_in = out_ff;
      if (cmd.load) begin
         x_in = operand_bits;
      end
      if (cmd.init) begin
         g_in  = (x_ff >= OneBits) ? (BiasTerm + (x_ff >> 1) - MantTerm) : fsn_halve(x_ff);
         xm_in = {x_ff[30:23] != 8'h00, x_ff[22:0]};
         xe_in = (x_ff[30:23] == 8'h00) ? -11'sd126
                                        : ($signed({3'b000, x_ff[30:23]}) - 11'sd127);
      end
      if (cmd.xshift) begin
         xm_in = {xm_ff[22:0], 1'b0};
         xe_in = xe_ff - 11'sd1;
      end
      if (cmd.set_inf) begin
         g_in = PosInfBits;
      end
      if (cmd.gload) begin
         gm_in = {g_ff[30:23] != 8'h00, g_ff[22:0]};
         ge_in = (g_ff[30:23] == 8'h00) ? -11'sd126
                                        : ($signed({3'b000, g_ff[30:23]}) - 11'sd127);
      end
      if (cmd.gshift) begin
         gm_in = {gm_ff[22:0], 1'b0};
         ge_in = ge_ff - 11'sd1;
      end
      if (cmd.div_setup) begin
         quo_in = '0;
         if (xm_ff < gm_ff) begin
            rem_in = {xm_ff, 1'b0};
            qe_in  = xe_ff - ge_ff + 11'sd126;
         end else begin
            rem_in = {1'b0, xm_ff};
            qe_in  = xe_ff - ge_ff + 11'sd127;
         end
      end
      if (cmd.div_iter) begin
         rem_in = {diff[23:0], 1'b0};
         quo_in = {quo_ff[24:0], sub_ok};
      end
      if (cmd.div_round) begin
         q_in = fsn_round(qe_ff, quo_ff, rem_ff != 25'd0);
      end
      if (cmd.add) begin
         s_in = fsn_add(g_ff, q_ff);
      end
      if (cmd.update) begin
         g_in = n_val;
      end
      if (cmd.capture) begin
         out_in = sts.special ? spec_val : g_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      g_ff   <= g_in;
      xm_ff  <= xm_in;
      xe_ff  <= xe_in;
      gm_ff  <= gm_in;
      ge_ff  <= ge_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      qe_ff  <= qe_in;
      q_ff   <= q_in;
      s_ff   <= s_in;
      out_ff <= out_in;
   end

   assign root_bits = out_ff;

endmodule

### src/fsn_controller.sv
// Controller: sequences special-case check, normalization, divide, add and halve.
module fsn_controller #(
   parameter int MAX_STEPS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  fsn_pkg::sts_type sts,
   output fsn_pkg::cmd_type cmd
);
   import fsn_pkg::*;

   localparam int CW = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PREP   = 4'd1;
   localparam logic [3:0] S_XNORM  = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_GNORM  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_ROUND  = 4'd6;
   localparam logic [3:0] S_ADD    = 4'd7;
   localparam logic [3:0] S_HALF   = 4'd8;
   localparam logic [3:0] S_FINISH = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   logic [4:0]    bit_ff, bit_in;
   logic          valid_ff, valid_in;
   logic          last_step;

   assign last_step = (step_ff + CW'(1)) == CW'(MAX_STEPS);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            step_in = '0;
            if (sts.special) begin
               state_in = S_FINISH;
            end else begin
               cmd.init = 1'b1;
               state_in = S_XNORM;
            end
         end
         S_XNORM: begin
            if (sts.x_norm) begin
               state_in = S_CHECK;
            end else begin
               cmd.xshift = 1'b1;
            end
         end
         S_CHECK: begin
            priority if (sts.g_inf) begin
               state_in = S_FINISH;
            end else if (sts.g_zero) begin
               cmd.set_inf = 1'b1;
               step_in     = step_ff + CW'(1);
               state_in    = last_step ? S_FINISH : S_CHECK;
            end else begin
               cmd.gload = 1'b1;
               state_in  = S_GNORM;
            end
         end
         S_GNORM: begin
            if (sts.g_norm) begin
               cmd.div_setup = 1'b1;
               bit_in        = '0;
               state_in      = S_DIV;
            end else begin
               cmd.gshift = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_iter = 1'b1;
            bit_in       = bit_ff + 5'd1;
            if (bit_ff == 5'(DivBits - 1)) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.div_round = 1'b1;
            state_in      = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_HALF;
         end
         S_HALF: begin
            if (sts.n_equal) begin
               state_in = S_FINISH;
            end else begin
               cmd.update = 1'b1;
               step_in    = step_ff + CW'(1);
               state_in   = last_step ? S_FINISH : S_CHECK;
            end
         end
         S_FINISH: begin
            if (!valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         bit_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### src/float_sqrt_newton_unit.sv
// Special operands go straight to the finish state; otherwise the operand is normalized, then
// each Newton step checks and loads the guess, normalizes it (subnormal guess only), divides,
// rounds the quotient, adds and halves. The unit takes one request at a time; the serial
// restoring divider produces one quotient bit per cycle, and there are up to MAX_STEPS steps.
// Reset: synchronous active-high reset returns the controller to idle and empties the
// response register.
module float_sqrt_newton_unit #(
   parameter int MAX_STEPS = 8
) (
   input logic       clock,
   input logic       reset,
   fsn_req_if.sink   req_if,
   fsn_rsp_if.source rsp_if
);
   import fsn_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fsn_controller #(
      .MAX_STEPS(MAX_STEPS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   fsn_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .operand_bits(req_if.operand_bits),
      .sts         (sts),
      .root_bits   (rsp_if.root_bits)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while busy");

   a_capture_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response overwritten");

   a_one_datapath_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_iter, cmd.div_round, cmd.add, cmd.update, cmd.capture}))
      else $error("conflicting datapath commands");

   a_capture_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_if.valid)
      else $error("response not presented");

endmodule

### test/tb_float_sqrt_newton_unit.sv
// Self-checking testbench for the Newton square root unit with a bit-exact float predictor.
module tb_float_sqrt_newton_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import fsn_pkg::*;

   localparam int ItemCount = 1950;

   logic clock;
   logic reset;
   fsn_req_if req_if ();
   fsn_rsp_if rsp_if ();

   float_sqrt_newton_unit #(.MAX_STEPS(8)) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   logic [31:0] operand_queue[$];
   logic [31:0] root_queue[$];
   int          idle_pct;
   int          stall_pct;
   int          mismatches;
   bit          req_taken;

   // round m * 2^e (plus sticky below lsb) to single precision, nearest even
   function automatic logic [31:0] float_round(input logic [63:0] m, input int e,
                                               input bit st);
      int          p;
      int          shift;
      logic [63:0] kept;
      logic [63:0] bits;
      bit          guard;
      bit          rest;
      p = 0;
      kept = '0;
      guard = 1'b0;
      rest = 1'b0;
      if (m == 0) return 32'd0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      shift = p - 23;
      if (-149 - e > shift) shift = -149 - e;
      if (shift <= 0) begin
         kept = m << (-shift);
      end else if (shift > 64) begin
         return 32'd0;
      end else begin
         kept  = (shift == 64) ? 64'd0 : m >> shift;
         guard = m[shift-1];
         rest  = st || ((m & ((64'd1 << (shift - 1)) - 64'd1)) != 0);
         kept  = kept + 64'(guard & (rest | kept[0]));
      end
      bits = (64'(e + shift + 149) << 23) + kept;
      if (bits >= 64'h7F80_0000) return PosInfBits;
      return bits[31:0];
   endfunction

   function automatic void float_unpack(input logic [31:0] a, output logic [63:0] m,
                                        output int e);
      if (a[30:23] == 8'd0) begin
         m = {41'd0, a[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] float_div(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      int          ea;
      int          eb;
      if (b[30:23] == 8'hFF) return 32'd0;
      if (b[30:0] == 0) return PosInfBits;
      float_unpack(a, ma, ea);
      float_unpack(b, mb, eb);
      while (!ma[23]) begin
         ma = ma << 1;
         ea = ea - 1;
      end
      return float_round((ma << 40) / mb, ea - eb - 40, ((ma << 40) % mb) != 0);
   endfunction

   function automatic logic [31:0] float_add(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] mt;
      int          ea;
      int          eb;
      int          et;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return PosInfBits;
      float_unpack(a, ma, ea);
      float_unpack(b, mb, eb);
      if (ea < eb) begin
         mt = ma; ma = mb; mb = mt;
         et = ea; ea = eb; eb = et;
      end
      if (ea - eb <= 40) return float_round((ma << (ea - eb)) + mb, eb, 1'b0);
      return float_round(ma << 2, ea - 2, mb != 0);
   endfunction

   function automatic logic [31:0] float_halve(input logic [31:0] a);
      logic [63:0] m;
      int          e;
      if (a[30:23] == 8'hFF) return a;
      float_unpack(a, m, e);
      return float_round(m, e - 1, 1'b0);
   endfunction

   function automatic logic [31:0] predict_root(input logic [31:0] x);
      logic [31:0] g;
      logic [31:0] n;
      if (x[30:23] == 8'hFF && x[22:0] != 0) return x | QuietBit;
      if (x[31] || x[30:0] == 0) return 32'd0;
      if (x == PosInfBits) return PosInfBits;
      if (x == OneBits) return OneBits;
      g = (x >= OneBits) ? BiasTerm + (x >> 1) - MantTerm : float_halve(x);
      for (int i = 0; i < 8; i++) begin
         n = float_halve(float_add(g, float_div(x, g)));
         if (n == g) break;
         g = n;
      end
      return g;
   endfunction

   function automatic logic [31:0] random_operand();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return $urandom();
      if (sel < 30) return {1'b0, 8'(126 + $urandom_range(1)), 23'($urandom())};
      if (sel < 40) return {9'd0, 23'($urandom() >> $urandom_range(22))};
      if (sel < 45) return {$urandom_range(1) == 1, 8'hFF, 23'($urandom() >> $urandom_range(22))};
      if (sel < 50) return {$urandom_range(1) == 1, 31'h3F80_0000};
      return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      logic        nv;
      logic [31:0] nd;
      nv = req_if.valid;
      nd = req_if.operand_bits;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_if.valid || req_taken) begin
         nv = 1'b0;
         if (operand_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nv = 1'b1;
            nd = operand_queue.pop_front();
         end
      end
      req_if.valid        <= nv;
      req_if.operand_bits <= nd;
      rsp_if.ready        <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      logic [31:0] want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            root_queue.push_back(predict_root(req_if.operand_bits));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (root_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_if.root_bits);
            end else begin
               want = root_queue.pop_front();
               if (rsp_if.root_bits !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("root mismatch: expected %h actual %h", want, rsp_if.root_bits);
               end
            end
         end
      end
   end

   task automatic run_phase(input int idle, input int stall, input int count);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) operand_queue.push_back(random_operand());
      while (operand_queue.size() > 0 || req_if.valid || root_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed[$];
      req_if.valid        = 1'b0;
      req_if.operand_bits = '0;
      rsp_if.ready        = 1'b0;
      req_taken           = 1'b0;
      idle_pct            = 0;
      stall_pct           = 0;
      mismatches          = 0;
      reset               = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // zeros, negatives, one, infinities, NaNs, subnormal edges, largest values
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F80_0000,
                   32'hFF80_0000, 32'h7FC0_0001, 32'h7F80_0001, 32'hFFBF_FFFF,
                   32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h007F_FFFF,
                   32'h0080_0000, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'h3F80_0001,
                   32'h4080_0000, 32'h4000_0000, 32'h3E80_0000, 32'hBF80_0000,
                   32'h5555_5555, 32'h2AAA_AAAA, 32'hFFFF_FFFF};
      foreach (directed[i]) operand_queue.push_back(directed[i]);
      run_phase(0, 0, 0);
      run_phase(0, 0, 480);
      run_phase(67, 0, 480);
      run_phase(0, 67, 480);
      run_phase(34, 34, 487);
      repeat (600) @(posedge clock);
      if (mismatches == 0 && root_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/fsn_pkg.sv
src/fsn_if.sv
src/fsn_datapath.sv
src/fsn_controller.sv
src/float_sqrt_newton_unit.sv
test/tb_float_sqrt_newton_unit.sv
